// ----- design/iot_pkg.sv -----
// shared types and constants for the interpolated operator table
// no dependencies; every other design file refers to this package by scoped names
package iot_pkg;

	localparam int ROWS_DEFAULT = 1024;
	localparam int TAPS_DEFAULT = 16;

	localparam int COEF_W = 24;
	localparam int DVD_W = 32;
	localparam int DSR_W = 16;
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEP = DVD_W / DIV_STAGES;

	localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SINGLE = 2'd1,
		OP_FULL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		REG_MIN_WAVENUMBER = 1'b0,
		REG_INVERSE_STEP   = 1'b1
	} reg_sel_t;

	// one request as it travels down the pipe
	typedef struct packed {
		op_t                      op;
		logic [3:0]               tap;
		logic [9:0]               row;
		logic                     wr_ok;
		logic                     tap_ok;
		logic signed [COEF_W-1:0] coef_re;
		logic signed [COEF_W-1:0] coef_im;
		logic                     keep;
	} item_t;

	// per-tap control from the table to the interpolator
	typedef struct packed {
		logic [3:0]  tap_index;
		logic        last;
		logic        oor;
		logic        keep;
		logic        halve;
		logic        zero;
		logic [15:0] frac;
	} tap_ctl_t;

endpackage

// ----- design/iot_div.sv -----
// pipelined restoring divider, DIV_STEP quotient bits per stage
// depends on iot_pkg
module iot_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  iot_pkg::item_t              in_item,
	input  logic [iot_pkg::DVD_W-1:0]   in_dvd,
	input  logic [iot_pkg::DSR_W-1:0]   in_dsr,
	output logic                        out_valid,
	output iot_pkg::item_t              out_item,
	output logic [iot_pkg::DVD_W-1:0]   out_quo
);
	localparam int NS = iot_pkg::DIV_STAGES;
	localparam int DW = iot_pkg::DVD_W;
	localparam int VW = iot_pkg::DSR_W;

	// index is the divider stage
	logic [NS-1:0]  vld_s;
	logic [DW-1:0]  x_s [NS];
	logic [VW-1:0]  r_s [NS];
	logic [VW-1:0]  d_s [NS];
	iot_pkg::item_t it_s [NS];

	logic [NS-1:0]  vld_in;
	logic [DW-1:0]  x_in [NS];
	logic [VW-1:0]  r_in [NS];
	logic [VW-1:0]  d_in [NS];
	iot_pkg::item_t it_in [NS];
	logic [DW-1:0]  x_nx [NS];
	logic [VW-1:0]  r_nx [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign vld_in[g] = in_valid;
			assign x_in[g] = in_dvd;
			assign r_in[g] = '0;
			assign d_in[g] = in_dsr;
			assign it_in[g] = in_item;
		end else begin : g_next
			assign vld_in[g] = vld_s[g-1];
			assign x_in[g] = x_s[g-1];
			assign r_in[g] = r_s[g-1];
			assign d_in[g] = d_s[g-1];
			assign it_in[g] = it_s[g-1];
		end

		// dividend shifts out the top while quotient bits enter the bottom
		always_comb begin
			logic [VW:0]   t;
			logic [VW-1:0] r;
			logic [DW-1:0] x;
			r = r_in[g];
			x = x_in[g];
			for (int i = 0; i < iot_pkg::DIV_STEP; i++) begin
				t = {r, x[DW-1]};
				x = {x[DW-2:0], 1'b0};
				if (t >= {1'b0, d_in[g]}) begin
					r = VW'(t - {1'b0, d_in[g]});
					x[0] = 1'b1;
				end else begin
					r = t[VW-1:0];
				end
			end
			r_nx[g] = r;
			x_nx[g] = x;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g] <= x_nx[g];
				r_s[g] <= r_nx[g];
				d_s[g] <= d_in[g];
				it_s[g] <= it_in[g];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_item = it_s[NS-1];
	assign out_quo = x_s[NS-1];

endmodule

// ----- design/iot_loc.sv -----
// row locator: offset, scale by inverse step, clamp into the table
// depends on iot_pkg
module iot_loc #(
	parameter int ROWS = iot_pkg::ROWS_DEFAULT,
	localparam int RW = $clog2(ROWS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  iot_pkg::item_t in_item,
	input  logic [31:0]    k,
	input  logic [31:0]    min_wavenumber,
	input  logic [31:0]    inverse_step,
	output logic           out_valid,
	output iot_pkg::item_t out_item,
	output logic [RW-1:0]  p1,
	output logic [RW-1:0]  p2,
	output logic [15:0]    frac,
	output logic           oor
);
	localparam logic [63:0] POS_LIM = {32'(ROWS - 1), 32'd0};
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic           valid_s6, valid_s7, valid_s8;
	iot_pkg::item_t item_s6, item_s7, item_s8;
	logic [31:0]    diff_s6;
	logic           below_s6, below_s7;
	logic [63:0]    pos_s7;
	logic [RW-1:0]  p1_s8, p2_s8;
	logic [15:0]    f_s8;
	logic           oor_s8;

	logic [32:0]    diff;
	logic [63:0]    prod;
	logic           over;
	logic [RW-1:0]  p1_nx, p2_nx;

	assign diff = {1'b0, k} - {1'b0, min_wavenumber};
	assign prod = diff_s6 * inverse_step;
	assign over = pos_s7 > POS_LIM;

	always_comb begin
		if (item_s7.op == iot_pkg::OP_WRITE) begin
			p1_nx = RW'(item_s7.row);
		end else if (over) begin
			p1_nx = LAST_ROW;
		end else begin
			p1_nx = pos_s7[32 +: RW];
		end
		p2_nx = (p1_nx != LAST_ROW) ? p1_nx + 1'b1 : p1_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s6 <= in_valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s6 <= in_item;
			diff_s6 <= diff[31:0];
			below_s6 <= diff[32];
			item_s7 <= item_s6;
			below_s7 <= below_s6;
			pos_s7 <= below_s6 ? 64'd0 : prod;
			item_s8 <= item_s7;
			p1_s8 <= p1_nx;
			p2_s8 <= p2_nx;
			f_s8 <= over ? 16'd0 : pos_s7[31:16];
			oor_s8 <= below_s7 | over;
		end
	end

	assign out_valid = valid_s8;
	assign out_item = item_s8;
	assign p1 = p1_s8;
	assign p2 = p2_s8;
	assign frac = f_s8;
	assign oor = oor_s8;

endmodule

// ----- design/iot_mem.sv -----
// tap store with one write and two read ports, and the per-tap sequencer
// depends on iot_pkg
module iot_mem #(
	parameter int ROWS = iot_pkg::ROWS_DEFAULT,
	parameter int TAPS = iot_pkg::TAPS_DEFAULT,
	localparam int RW = $clog2(ROWS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  iot_pkg::item_t                     in_item,
	input  logic [RW-1:0]                      p1,
	input  logic [RW-1:0]                      p2,
	input  logic [15:0]                        frac,
	input  logic                               oor,
	output logic                               hold,
	output logic                               out_valid,
	output iot_pkg::tap_ctl_t                  out_ctl,
	output logic signed [iot_pkg::COEF_W-1:0]  a_re,
	output logic signed [iot_pkg::COEF_W-1:0]  b_re,
	output logic signed [iot_pkg::COEF_W-1:0]  a_im,
	output logic signed [iot_pkg::COEF_W-1:0]  b_im
);
	localparam int DEPTH = ROWS * TAPS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [CW-1:0] LAST_TAP = CW'(TAPS - 1);

	logic signed [iot_pkg::COEF_W-1:0] mem_re [DEPTH];
	logic signed [iot_pkg::COEF_W-1:0] mem_im [DEPTH];

	logic              valid_s9, valid_s10;
	iot_pkg::item_t    item_s9;
	logic [AW-1:0]     base_a_s9, base_b_s9;
	logic [15:0]       f_s9;
	logic              oor_s9;
	logic [CW-1:0]     cnt_q;
	iot_pkg::tap_ctl_t ctl_s10;
	logic signed [iot_pkg::COEF_W-1:0] a_re_s10, b_re_s10, a_im_s10, b_im_s10;

	logic          full, issue, wr_en;
	logic [AW-1:0] tap_sel, addr_a, addr_b;

	assign full = item_s9.op == iot_pkg::OP_FULL;
	assign issue = valid_s9 && (full || item_s9.op == iot_pkg::OP_SINGLE);
	assign wr_en = valid_s9 && item_s9.op == iot_pkg::OP_WRITE && item_s9.wr_ok;
	assign hold = valid_s9 && full && cnt_q != LAST_TAP;

	always_comb begin
		if (full) begin
			tap_sel = AW'(cnt_q);
		end else if (item_s9.tap_ok) begin
			tap_sel = AW'(item_s9.tap);
		end else begin
			tap_sel = '0;
		end
	end

	assign addr_a = base_a_s9 + tap_sel;
	assign addr_b = base_b_s9 + tap_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
			valid_s10 <= 1'b0;
			cnt_q <= '0;
		end else begin
			valid_s10 <= issue;
			if (hold) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				valid_s9 <= in_valid;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			item_s9 <= in_item;
			base_a_s9 <= AW'(32'(p1) * 32'(TAPS));
			base_b_s9 <= AW'(32'(p2) * 32'(TAPS));
			f_s9 <= frac;
			oor_s9 <= oor;
		end
		ctl_s10.tap_index <= full ? 4'(cnt_q) : item_s9.tap;
		ctl_s10.last <= full ? (cnt_q == LAST_TAP) : 1'b1;
		ctl_s10.oor <= oor_s9;
		ctl_s10.keep <= item_s9.keep;
		ctl_s10.halve <= full;
		ctl_s10.zero <= !full && !item_s9.tap_ok;
		ctl_s10.frac <= f_s9;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_re[addr_a] <= item_s9.coef_re;
			mem_im[addr_a] <= item_s9.coef_im;
		end
		a_re_s10 <= mem_re[addr_a];
		b_re_s10 <= mem_re[addr_b];
		a_im_s10 <= mem_im[addr_a];
		b_im_s10 <= mem_im[addr_b];
	end

	assign out_valid = valid_s10;
	assign out_ctl = ctl_s10;
	assign a_re = a_re_s10;
	assign b_re = b_re_s10;
	assign a_im = a_im_s10;
	assign b_im = b_im_s10;

	a_hold_steps: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> valid_s9 && full && cnt_q == $past(cnt_q) + 1'b1)
		else $error("sequencer lost or skipped a tap");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (valid_s9 && full))
		else $error("tap counter running without a full lookup");

	a_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 |-> $past(valid_s9) && $past(item_s9.op) != iot_pkg::OP_WRITE)
		else $error("read data marked valid without a lookup");

endmodule

// ----- design/iot_interp.sv -----
// linear interpolation between two rows, halving and imaginary sign
// depends on iot_pkg
module iot_interp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  iot_pkg::tap_ctl_t                  in_ctl,
	input  logic signed [iot_pkg::COEF_W-1:0]  a_re,
	input  logic signed [iot_pkg::COEF_W-1:0]  b_re,
	input  logic signed [iot_pkg::COEF_W-1:0]  a_im,
	input  logic signed [iot_pkg::COEF_W-1:0]  b_im,
	output logic                               out_valid,
	output logic signed [iot_pkg::COEF_W-1:0]  op_re,
	output logic signed [iot_pkg::COEF_W-1:0]  op_im,
	output logic [3:0]                         tap_index,
	output logic                               last,
	output logic                               oor
);
	localparam int CW = iot_pkg::COEF_W;
	localparam int PW = CW + 18;

	logic              valid_s11, valid_s12;
	iot_pkg::tap_ctl_t ctl_s11;
	logic signed [PW-1:0] prod_re_s11, prod_im_s11;
	logic signed [CW-1:0] a_re_s11, a_im_s11;
	logic signed [CW-1:0] re_s12, im_s12;
	logic [3:0]        tap_s12;
	logic              last_s12, oor_s12;

	logic signed [CW:0]   d_re, d_im;
	logic signed [CW-1:0] re_nx, im_nx, im_res;

	assign d_re = $signed({b_re[CW-1], b_re}) - $signed({a_re[CW-1], a_re});
	assign d_im = $signed({b_im[CW-1], b_im}) - $signed({a_im[CW-1], a_im});

	function automatic logic signed [CW-1:0] finish(
		input logic signed [CW-1:0] a,
		input logic signed [PW-1:0] prod,
		input logic                 halve
	);
		logic signed [PW-1:0] rnd;
		logic signed [CW+1:0] v;
		logic signed [CW+2:0] vp;
		rnd = prod + PW'(32768);
		v = $signed({{2{a[CW-1]}}, a}) + $signed(rnd[PW-1:16]);
		vp = $signed({v[CW+1], v}) + 2'sb01;
		if (halve) begin
			finish = vp[CW:1];
		end else begin
			finish = v[CW-1:0];
		end
	endfunction

	always_comb begin
		re_nx = finish(a_re_s11, prod_re_s11, ctl_s11.halve);
		im_res = finish(a_im_s11, prod_im_s11, ctl_s11.halve);
		if (ctl_s11.keep) begin
			im_nx = im_res;
		end else if (im_res == {1'b1, {(CW-1){1'b0}}}) begin
			im_nx = {1'b0, {(CW-1){1'b1}}};
		end else begin
			im_nx = -im_res;
		end
		if (ctl_s11.zero) begin
			re_nx = '0;
			im_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			valid_s11 <= in_valid;
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s11 <= in_ctl;
		a_re_s11 <= a_re;
		a_im_s11 <= a_im;
		prod_re_s11 <= d_re * $signed({1'b0, in_ctl.frac});
		prod_im_s11 <= d_im * $signed({1'b0, in_ctl.frac});
		re_s12 <= re_nx;
		im_s12 <= im_nx;
		tap_s12 <= ctl_s11.tap_index;
		last_s12 <= ctl_s11.last;
		oor_s12 <= ctl_s11.oor;
	end

	assign out_valid = valid_s12;
	assign op_re = re_s12;
	assign op_im = im_s12;
	assign tap_index = tap_s12;
	assign last = last_s12;
	assign oor = oor_s12;

endmodule

// ----- design/interpolated_operator_table.sv -----
// top level of the interpolated operator table: request capture, config registers, pipe
// depends on iot_pkg, iot_div, iot_loc, iot_mem, iot_interp
//
// channel  | handshake                         | payload
// ---------+-----------------------------------+---------------------------------------------
// request  | start, busy (taken: start & !busy)| operation row tap coef_re coef_im wavenumber
//          |                                   | frequency velocity mode_negative
// result   | valid, one cycle, never stalled   | op_re op_im tap_index last out_of_range
// config   | psel penable pwrite paddr pwdata  | min_wavenumber at 0, inverse_step at 4
//          | prdata pready (pready tied high)  |
//
// twelve register stages: request capture, four divider stages (8 quotient bits each),
// offset, multiply by the inverse step, clamp, sequencer and table read, read data,
// difference times fraction, round and sign.
// writes and single tap lookups go in one per cycle while busy is low; a full lookup
// keeps the sequencer for one table read per tap; busy is high for all but the last tap.
// reset clears valid bits, the tap counter and min_wavenumber, and loads INV_STEP_RESET into
// inverse_step; table contents stay undefined until written, so no clearing pass is needed.
// busy only freezes the stages ahead of the sequencer; results always flow out.
module interpolated_operator_table #(
	parameter int ROWS = iot_pkg::ROWS_DEFAULT,
	parameter int TAPS = iot_pkg::TAPS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         operation,
	input  logic [9:0]                         row,
	input  logic [3:0]                         tap,
	input  logic signed [23:0]                 coef_re,
	input  logic signed [23:0]                 coef_im,
	input  logic [31:0]                        wavenumber,
	input  logic [31:0]                        frequency,
	input  logic [15:0]                        velocity,
	input  logic                               mode_negative,
	// result
	output logic                               valid,
	output logic signed [23:0]                 op_re,
	output logic signed [23:0]                 op_im,
	output logic [3:0]                         tap_index,
	output logic                               last,
	output logic                               out_of_range,
	// config
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	localparam int RW = $clog2(ROWS);

	// config registers
	logic [31:0] min_wavenumber_q, inverse_step_q;
	iot_pkg::reg_sel_t reg_sel;

	assign reg_sel = iot_pkg::reg_sel_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wavenumber_q <= '0;
			inverse_step_q <= iot_pkg::INV_STEP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				iot_pkg::REG_MIN_WAVENUMBER: min_wavenumber_q <= pwdata;
				iot_pkg::REG_INVERSE_STEP:   inverse_step_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			iot_pkg::REG_MIN_WAVENUMBER: prdata = min_wavenumber_q;
			iot_pkg::REG_INVERSE_STEP:   prdata = inverse_step_q;
		endcase
	end

	// request capture; operation code 3 is dropped here
	logic              hold, en, accept;
	logic              valid_s1;
	iot_pkg::item_t    item_s1, item_nx;
	logic [31:0]       dvd_s1;
	logic [15:0]       dsr_s1;
	iot_pkg::op_t      op_in;

	assign busy = hold;
	assign en = !hold;
	assign accept = start && !busy;
	assign op_in = iot_pkg::op_t'(operation);

	always_comb begin
		item_nx.op = op_in;
		item_nx.tap = tap;
		item_nx.row = row;
		item_nx.wr_ok = (32'(row) < 32'(ROWS)) && (32'(tap) < 32'(TAPS));
		item_nx.tap_ok = 32'(tap) < 32'(TAPS);
		item_nx.coef_re = coef_re;
		item_nx.coef_im = coef_im;
		item_nx.keep = mode_negative;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && op_in != iot_pkg::OP_NONE;
		end
	end

	// a full lookup divides its wavenumber by one so both lookups share the divider
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_nx;
			dvd_s1 <= (op_in == iot_pkg::OP_FULL) ? wavenumber : frequency;
			dsr_s1 <= (op_in == iot_pkg::OP_FULL) ? 16'd1 : velocity;
		end
	end

	// divider: k = frequency / velocity (all ones for a zero velocity), or the wavenumber for a full lookup
	logic           div_valid;
	iot_pkg::item_t div_item;
	logic [31:0]    div_quo;

	iot_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_item   (item_s1),
		.in_dvd    (dvd_s1),
		.in_dsr    (dsr_s1),
		.out_valid (div_valid),
		.out_item  (div_item),
		.out_quo   (div_quo)
	);

	// row position and clamp
	logic           loc_valid;
	iot_pkg::item_t loc_item;
	logic [RW-1:0]  loc_p1, loc_p2;
	logic [15:0]    loc_frac;
	logic           loc_oor;

	iot_loc #(.ROWS(ROWS)) u_loc (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (div_valid),
		.in_item        (div_item),
		.k              (div_quo),
		.min_wavenumber (min_wavenumber_q),
		.inverse_step   (inverse_step_q),
		.out_valid      (loc_valid),
		.out_item       (loc_item),
		.p1             (loc_p1),
		.p2             (loc_p2),
		.frac           (loc_frac),
		.oor            (loc_oor)
	);

	// tap store and sequencer
	logic              mem_valid;
	iot_pkg::tap_ctl_t mem_ctl;
	logic signed [23:0] a_re, b_re, a_im, b_im;

	iot_mem #(.ROWS(ROWS), .TAPS(TAPS)) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (loc_valid),
		.in_item   (loc_item),
		.p1        (loc_p1),
		.p2        (loc_p2),
		.frac      (loc_frac),
		.oor       (loc_oor),
		.hold      (hold),
		.out_valid (mem_valid),
		.out_ctl   (mem_ctl),
		.a_re      (a_re),
		.b_re      (b_re),
		.a_im      (a_im),
		.b_im      (b_im)
	);

	// interpolation and output register
	iot_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mem_valid),
		.in_ctl    (mem_ctl),
		.a_re      (a_re),
		.b_re      (b_re),
		.a_im      (a_im),
		.b_im      (b_im),
		.out_valid (valid),
		.op_re     (op_re),
		.op_im     (op_im),
		.tap_index (tap_index),
		.last      (last),
		.oor       (out_of_range)
	);

	// the taps of one full lookup leave back to back, in order
	a_taps_in_a_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid && tap_index == $past(tap_index) + 4'd1)
		else $error("full lookup results not consecutive");

endmodule
